### src/headset_key_adc_qualifier_core_defines.svh
// Assertion macros for the headset key ADC qualifier.
// Used by headset_key_adc_qualifier_core.sv; depends on nothing.
`ifndef HEADSET_KEY_ADC_QUALIFIER_CORE_DEFINES_SVH
`define HEADSET_KEY_ADC_QUALIFIER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define HKAQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define HKAQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/hkaq_pkg.sv
// Shared codes, reset values and result type for the headset key ADC qualifier.
// No dependencies.
`default_nettype none

package hkaq_pkg;

    localparam int LIMIT_W = 10;
    localparam int MIN_W   = 4;
    localparam int RANGE_CNT_W = 4;
    localparam int OUT_DATA_W  = 8;

    localparam logic [1:0] REQ_KEY_EDGE   = 2'd0;
    localparam logic [1:0] REQ_CHECK_TICK = 2'd1;
    localparam logic [1:0] REQ_DETACH     = 2'd2;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;

    localparam logic [1:0] REPORT_NONE    = 2'd0;
    localparam logic [1:0] REPORT_PRESS   = 2'd1;
    localparam logic [1:0] REPORT_RELEASE = 2'd2;

    localparam logic [1:0] REG_IN_RANGE_LIMIT = 2'd0;
    localparam logic [1:0] REG_QUIET_LIMIT    = 2'd1;
    localparam logic [1:0] REG_FAST_AVG_LIMIT = 2'd2;
    localparam logic [1:0] REG_MIN_IN_RANGE   = 2'd3;

    localparam logic [LIMIT_W-1:0] IN_RANGE_LIMIT_RST = 10'd150;
    localparam logic [LIMIT_W-1:0] QUIET_LIMIT_RST    = 10'd75;
    localparam logic [LIMIT_W-1:0] FAST_AVG_LIMIT_RST = 10'd100;
    localparam logic [MIN_W-1:0]   MIN_IN_RANGE_RST   = 4'd2;

    typedef struct packed {
        logic       check_pending;
        logic       switch_shown;
        logic [1:0] hook_report;
    } result_t;

endpackage

`default_nettype wire

### src/headset_key_adc_qualifier_core.sv
// Headset hook button qualifier: one result word for every input word, registered once
// the word is taken. All decision logic sits between the input handshake and a result
// register, so a word is taken in every cycle while s_tready is high; a skid register behind
// the result register keeps s_tready high while one finished result waits on m_tready, and
// s_tready drops only while both hold a result. Input kind (s_tuser): key edge, check tick,
// detach release. Registers: 0x0 in-range limit, 0x4 quiet limit, 0x8 fast-average limit,
// 0xC minimum in-range count; write them only while no word is in flight.
// Depends on hkaq_pkg and headset_key_adc_qualifier_core_defines.svh.
`default_nettype none
`include "headset_key_adc_qualifier_core_defines.svh"

module headset_key_adc_qualifier_core #(
    parameter int CHECK_TICKS = 3,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // s_tdata, from bit 0: key_level, mic_headset, irq_enabled, check_sample,
    // fast_sample_a, fast_sample_b, zero fill to whole bytes
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [((3 + 3*SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: req_type
    input  wire logic [1:0]             s_tuser,
    // m_tdata, from bit 0: hook_report[1:0], switch_shown, check_pending, zero fill
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [hkaq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [3:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int CNT_W = $clog2(CHECK_TICKS + 1);
    localparam int CMP_W = (SAMPLE_BITS > hkaq_pkg::LIMIT_W) ? SAMPLE_BITS : hkaq_pkg::LIMIT_W;
    localparam int RES_W = $bits(hkaq_pkg::result_t);

    // configuration
    logic [hkaq_pkg::LIMIT_W-1:0] in_range_limit_reg;
    logic [hkaq_pkg::LIMIT_W-1:0] quiet_limit_reg;
    logic [hkaq_pkg::LIMIT_W-1:0] fast_avg_limit_reg;
    logic [hkaq_pkg::MIN_W-1:0]   min_in_range_reg;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_range_limit_reg <= hkaq_pkg::IN_RANGE_LIMIT_RST;
            quiet_limit_reg    <= hkaq_pkg::QUIET_LIMIT_RST;
            fast_avg_limit_reg <= hkaq_pkg::FAST_AVG_LIMIT_RST;
            min_in_range_reg   <= hkaq_pkg::MIN_IN_RANGE_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                hkaq_pkg::REG_IN_RANGE_LIMIT: in_range_limit_reg <= pwdata[hkaq_pkg::LIMIT_W-1:0];
                hkaq_pkg::REG_QUIET_LIMIT:    quiet_limit_reg    <= pwdata[hkaq_pkg::LIMIT_W-1:0];
                hkaq_pkg::REG_FAST_AVG_LIMIT: fast_avg_limit_reg <= pwdata[hkaq_pkg::LIMIT_W-1:0];
                hkaq_pkg::REG_MIN_IN_RANGE:   min_in_range_reg   <= pwdata[hkaq_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            hkaq_pkg::REG_IN_RANGE_LIMIT: prdata = 32'(in_range_limit_reg);
            hkaq_pkg::REG_QUIET_LIMIT:    prdata = 32'(quiet_limit_reg);
            hkaq_pkg::REG_FAST_AVG_LIMIT: prdata = 32'(fast_avg_limit_reg);
            hkaq_pkg::REG_MIN_IN_RANGE:   prdata = 32'(min_in_range_reg);
            default:                      prdata = '0;
        endcase
    end

    // input word fields
    logic [1:0]             req_type;
    logic                   key_level;
    logic                   mic_headset;
    logic                   irq_enabled;
    logic [SAMPLE_BITS-1:0] check_sample;
    logic [SAMPLE_BITS-1:0] fast_sample_a;
    logic [SAMPLE_BITS-1:0] fast_sample_b;
    logic [SAMPLE_BITS:0]   fast_sum;

    assign req_type      = s_tuser;
    assign key_level     = s_tdata[0];
    assign mic_headset   = s_tdata[1];
    assign irq_enabled   = s_tdata[2];
    assign check_sample  = s_tdata[3 +: SAMPLE_BITS];
    assign fast_sample_a = s_tdata[3 + SAMPLE_BITS +: SAMPLE_BITS];
    assign fast_sample_b = s_tdata[3 + 2*SAMPLE_BITS +: SAMPLE_BITS];
    assign fast_sum      = {1'b0, fast_sample_a} + {1'b0, fast_sample_b};

    // qualifier state
    logic                            check_armed_reg, check_armed_next;
    logic [CNT_W-1:0]                tick_count_reg, tick_count_next;
    logic [hkaq_pkg::RANGE_CNT_W-1:0] in_range_count_reg, in_range_count_next;
    logic [CNT_W-1:0]                sample_index_reg, sample_index_next;
    logic [SAMPLE_BITS-1:0]          sample_store_reg [CHECK_TICKS];
    logic [SAMPLE_BITS-1:0]          fast_avg_reg, fast_avg_next;
    logic                            key_held_reg, key_held_next;
    logic                            switch_state_reg, switch_state_next;
    logic                            store_write;
    logic                            store_clear;
    logic                            all_quiet;
    logic                            decide;
    logic [1:0]                      report;
    logic                            push;
    hkaq_pkg::result_t               result;

    assign push = s_tvalid && s_tready;

    always_comb begin
        all_quiet = 1'b1;
        for (int i = 0; i < CHECK_TICKS; i++) begin
            if (CMP_W'(sample_store_reg[i]) >= CMP_W'(quiet_limit_reg)) begin
                all_quiet = 1'b0;
            end
        end
    end

    always_comb begin
        check_armed_next    = check_armed_reg;
        tick_count_next     = tick_count_reg;
        in_range_count_next = in_range_count_reg;
        sample_index_next   = sample_index_reg;
        fast_avg_next       = fast_avg_reg;
        key_held_next       = key_held_reg;
        switch_state_next   = switch_state_reg;
        store_write         = 1'b0;
        store_clear         = 1'b0;
        decide              = 1'b0;
        report              = hkaq_pkg::REPORT_NONE;
        case (req_type)
            hkaq_pkg::REQ_KEY_EDGE: begin
                if (irq_enabled) begin
                    if (key_level) begin
                        fast_avg_next = fast_sum[SAMPLE_BITS:1];
                    end
                    check_armed_next = 1'b0;
                    tick_count_next  = '0;
                    if (mic_headset) begin
                        if (key_level) begin
                            check_armed_next = 1'b1;
                        end else begin
                            report            = hkaq_pkg::REPORT_RELEASE;
                            key_held_next     = 1'b0;
                            switch_state_next = 1'b0;
                        end
                    end
                end
            end
            hkaq_pkg::REQ_CHECK_TICK: begin
                if (check_armed_reg) begin
                    if (mic_headset && key_level) begin
                        if (tick_count_reg < CNT_W'(CHECK_TICKS)) begin
                            tick_count_next = tick_count_reg + 1'b1;
                            if (CMP_W'(check_sample) <= CMP_W'(in_range_limit_reg)
                                && in_range_count_reg != '1) begin
                                in_range_count_next = in_range_count_reg + 1'b1;
                            end
                            if (sample_index_reg < CNT_W'(CHECK_TICKS)) begin
                                store_write       = 1'b1;
                                sample_index_next = sample_index_reg + 1'b1;
                            end
                        end else begin
                            decide        = 1'b1;
                            key_held_next = 1'b1;
                            if (in_range_count_reg >= min_in_range_reg
                                || (CMP_W'(fast_avg_reg) < CMP_W'(fast_avg_limit_reg)
                                    && all_quiet)) begin
                                report = hkaq_pkg::REPORT_PRESS;
                            end
                            store_clear         = 1'b1;
                            in_range_count_next = '0;
                            sample_index_next   = '0;
                            switch_state_next   = 1'b1;
                            tick_count_next     = '0;
                            check_armed_next    = 1'b0;
                        end
                    end else begin
                        store_clear         = 1'b1;
                        in_range_count_next = '0;
                        sample_index_next   = '0;
                        check_armed_next    = 1'b0;
                    end
                end
            end
            hkaq_pkg::REQ_DETACH: begin
                if (key_held_reg) begin
                    report            = hkaq_pkg::REPORT_RELEASE;
                    key_held_next     = 1'b0;
                    switch_state_next = 1'b0;
                end
            end
            default: ;
        endcase
        result.hook_report   = report;
        result.switch_shown  = switch_state_next;
        result.check_pending = check_armed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_armed_reg    <= 1'b0;
            tick_count_reg     <= '0;
            in_range_count_reg <= '0;
            sample_index_reg   <= '0;
            fast_avg_reg       <= '0;
            key_held_reg       <= 1'b0;
            switch_state_reg   <= 1'b0;
            for (int i = 0; i < CHECK_TICKS; i++) begin
                sample_store_reg[i] <= '0;
            end
        end else if (push) begin
            check_armed_reg    <= check_armed_next;
            tick_count_reg     <= tick_count_next;
            in_range_count_reg <= in_range_count_next;
            sample_index_reg   <= sample_index_next;
            fast_avg_reg       <= fast_avg_next;
            key_held_reg       <= key_held_next;
            switch_state_reg   <= switch_state_next;
            for (int i = 0; i < CHECK_TICKS; i++) begin
                if (store_clear) begin
                    sample_store_reg[i] <= '0;
                end else if (store_write && sample_index_reg == CNT_W'(i)) begin
                    sample_store_reg[i] <= check_sample;
                end
            end
        end
    end

    // result register with skid stage
    logic              out_valid_reg;
    logic              skid_valid_reg;
    hkaq_pkg::result_t out_data_reg;
    hkaq_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop      = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hkaq_pkg::OUT_DATA_W - RES_W){1'b0}}, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= result;
            end else begin
                skid_data_reg <= result;
            end
        end
    end

    `HKAQ_ASSERT_SAME(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg, "skid holds a word while the result register is empty")
    `HKAQ_ASSERT_SAME(a_counts_bounded, aclk, aresetn, 1'b1, (tick_count_reg <= CNT_W'(CHECK_TICKS)) && (sample_index_reg <= CNT_W'(CHECK_TICKS)), "tick or sample count past the check length")
    `HKAQ_ASSERT_NEXT(a_decide_clears, aclk, aresetn, push && decide, !check_armed_reg && sample_index_reg == '0 && in_range_count_reg == '0 && tick_count_reg == '0, "deciding tick left the check state set")

endmodule

`default_nettype wire
